// ===== rtl/utrd_pkg.sv =====
// Shared types, widths and digit encoding for the radix digit converter.
`default_nettype none
package utrd_pkg;

   localparam int VALUE_W    = 32;
   localparam int VALUE_BITS = 32;
   localparam int RADIX_W    = 5;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;
   localparam int DIGIT_CAP  = 32;
   localparam int IDX_W      = $clog2(DIGIT_CAP);
   localparam int CHUNK_BITS = 8;
   localparam int CHUNKS     = VALUE_W / CHUNK_BITS;
   localparam int STEP_W     = $clog2(CHUNKS);

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   localparam logic [63:0] PARAM_MASK = (64'(1) << (VALUE_BITS - 1)) * 64'd2 - 64'd1;
   localparam logic [VALUE_W-1:0] VALUE_MASK = PARAM_MASK[VALUE_W-1:0];

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] ASCII_UPPER = CHAR_W'(55);  // 'A' - 10
   localparam logic [CHAR_W-1:0] ASCII_LOWER = CHAR_W'(87);  // 'a' - 10

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic               upper_case;
   } item_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
      logic [CHAR_W-1:0] base;
      if (d < DIGIT_W'(10)) begin
         base = ASCII_ZERO;
      end else if (upper) begin
         base = ASCII_UPPER;
      end else begin
         base = ASCII_LOWER;
      end
      return base + CHAR_W'(d);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/utrd_front.sv =====
// Front end: masks the value and saturates the radix into the legal range.
`default_nettype none
module utrd_front (
   input  wire logic [utrd_pkg::VALUE_W-1:0] value,
   input  wire logic [utrd_pkg::RADIX_W-1:0] radix,
   input  wire logic                         upper_case,
   output utrd_pkg::item_type                item
);
   import utrd_pkg::*;

   always_comb begin
      item.value      = value & VALUE_MASK;
      item.upper_case = upper_case;
      if (radix < RADIX_MIN) begin
         item.radix = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         item.radix = RADIX_MAX;
      end else begin
         item.radix = radix;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/utrd_queue.sv =====
// Two-entry item queue between the front end and the digit engine.
`default_nettype none
module utrd_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire utrd_pkg::item_type push_item,
   output logic             full,
   input  wire logic        pop,
   output utrd_pkg::item_type pop_item,
   output logic             empty
);
   import utrd_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/utrd_back.sv =====
// Digit engine: iterative division by the radix, digit buffer, output register.
`default_nettype none
module utrd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_empty,
   input  wire utrd_pkg::item_type          q_item,
   output logic                             q_pop,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [utrd_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                             rsp_last
);
   import utrd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [RADIX_W-1:0] rad_ff, rad_in;
   logic               upper_ff, upper_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DIGIT_W-1:0] buf_ff [DIGIT_CAP];
   logic               buf_we;

   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff;
   logic               out_last_ff;
   logic               out_load;
   logic               out_free;

   logic [DIGIT_W-1:0]    div_rem;
   logic [CHUNK_BITS-1:0] div_q;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;
   assign out_free       = !out_valid_ff || rsp_pop;

   // One chunk of restoring division per cycle; remainder stays below the radix.
   always_comb begin
      logic [DIGIT_W:0] r;
      r     = {1'b0, rem_ff};
      div_q = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         r = {r[DIGIT_W-1:0], quot_ff[VALUE_W - CHUNK_BITS + i]};
         if (r >= (DIGIT_W+1)'(rad_ff)) begin
            r = r - (DIGIT_W+1)'(rad_ff);
            div_q[i] = 1'b1;
         end
      end
      div_rem = r[DIGIT_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      quot_in      = quot_ff;
      rad_in       = rad_ff;
      upper_in     = upper_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      buf_we       = 1'b0;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               quot_in  = q_item.value;
               rad_in   = q_item.radix;
               upper_in = q_item.upper_case;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = {quot_ff[VALUE_W-CHUNK_BITS-1:0], div_q};
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CHUNKS - 1)) begin
               // quot_in now holds the full quotient, div_rem the digit
               buf_we  = 1'b1;
               rem_in  = '0;
               if (quot_in == '0 || cnt_ff == IDX_W'(DIGIT_CAP - 1)) begin
                  idx_in   = cnt_ff;
                  state_in = ST_EMIT;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[cnt_ff] <= div_rem;
      end
      if (out_load) begin
         out_char_ff <= digit_to_char(buf_ff[idx_ff], upper_ff);
         out_last_ff <= (idx_ff == '0);
      end
      quot_ff  <= quot_in;
      rad_ff   <= rad_in;
      upper_ff <= upper_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/unsigned_to_radix_digits.sv =====
// Top level: unsigned value to ASCII digits in radix 2..16, most significant first.
// Each digit comes from one pass of the divider over all 32 bits, 8 quotient bits a cycle.
// The digits stream from the output register at one per cycle while the receiver pops
// each one; the engine converts one item at a time, and the two-entry queue takes new
// requests meanwhile until it is full.
// Synchronous active-high reset empties the item queue and the output register.
`default_nettype none
module unsigned_to_radix_digits (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic [utrd_pkg::VALUE_W-1:0] req_value,
   input  wire logic [utrd_pkg::RADIX_W-1:0] req_radix,
   input  wire logic                       req_upper_case,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [utrd_pkg::CHAR_W-1:0]     rsp_digit_char,
   output logic                            rsp_last
);
   import utrd_pkg::*;

   item_type front_item;
   item_type q_item;
   logic     q_empty;
   logic     q_pop;

   utrd_front u_front (
      .value      (req_value),
      .radix      (req_radix),
      .upper_case (req_upper_case),
      .item       (front_item)
   );

   utrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   utrd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

// ===== dv/unsigned_to_radix_digits_tb.sv =====
// Testbench for unsigned_to_radix_digits: random and directed values checked digit by digit.
`timescale 1ns / 1ps
module unsigned_to_radix_digits_tb;
   import utrd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } digit_exp_type;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [VALUE_W-1:0]  req_value;
   logic [RADIX_W-1:0]  req_radix;
   logic                req_upper_case;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [CHAR_W-1:0]   rsp_digit_char;
   logic                rsp_last;

   digit_exp_type  expected_digits[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          rx_hold_cycles = 0;
   bit          steady_mode = 1'b0;

   unsigned_to_radix_digits dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .req_upper_case (req_upper_case),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Append the digits of one value, most significant first, to the expected queue.
   function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                          input logic [RADIX_W-1:0] radix,
                                          input logic upper);
      digit_exp_type digits[$];
      digit_exp_type one;
      logic [31:0]  rest;
      int unsigned  base;
      int unsigned  d;
      string        glyphs;
      byte          ch;
      rest = value & VALUE_MASK;
      base = radix;
      if (base < 2) base = 2;
      if (base > 16) base = 16;
      glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
      do begin
         d = rest % base;
         ch = glyphs[d];
         one.code = ch[CHAR_W-1:0];
         one.last = 1'b0;
         digits.push_front(one);
         rest = rest / base;
      end while (rest != 0 && digits.size() < DIGIT_CAP);
      digits[digits.size()-1].last = 1'b1;
      foreach (digits[i]) expected_digits.push_back(digits[i]);
   endfunction

   // Called right after a falling edge; returns right after the falling edge past the transfer.
   task automatic send_item(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix,
                            input logic upper);
      req_push = 1'b0;
      while (!steady_mode && $urandom_range(0, 99) < 19) @(negedge clock);
      req_value      = value;
      req_radix      = radix;
      req_upper_case = upper;
      req_push       = 1'b1;
      do @(posedge clock); while (req_full !== 1'b0);
      predict_digits(value, radix, upper);
      @(negedge clock);
      req_push = 1'b0;
   endtask

   task automatic wait_results_drained();
      while (expected_digits.size() != 0) @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned k;
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 4))
         0: return VALUE_W'($urandom_range(0, 255));
         1: return VALUE_W'(1) << k;
         2: return (VALUE_W'(1) << k) - VALUE_W'(1);
         3: return {VALUE_W{1'b1}} >> k;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [RADIX_W-1:0] pick_radix();
      // Mostly legal bases, sometimes anything the field can hold.
      if ($urandom_range(0, 9) == 0) return RADIX_W'($urandom_range(0, 31));
      return RADIX_W'($urandom_range(2, 16));
   endfunction

   task automatic test_directed();
      send_item(32'd0, 5'd10, 1'b0);
      send_item(32'd0, 5'd2, 1'b1);
      send_item(32'hFFFF_FFFF, 5'd2, 1'b0);
      send_item(32'h8000_0000, 5'd2, 1'b1);
      send_item(32'hFFFF_FFFF, 5'd16, 1'b1);
      send_item(32'hFFFF_FFFF, 5'd16, 1'b0);
      send_item(32'hFFFF_FFFF, 5'd10, 1'b0);
      send_item(32'hFFFF_FFFF, 5'd3, 1'b1);
      send_item(32'hDEAD_BEEF, 5'd16, 1'b1);
      send_item(32'hCAFE_F00D, 5'd16, 1'b0);
      send_item(32'd1, 5'd7, 1'b0);
      send_item(32'd15, 5'd16, 1'b0);
      send_item(32'd16, 5'd16, 1'b1);
      send_item(32'd9, 5'd10, 1'b0);
      send_item(32'd10, 5'd10, 1'b1);
      send_item(32'd14, 5'd15, 1'b1);
      send_item(32'd12345, 5'd11, 1'b0);
      send_item(32'd12345, 5'd13, 1'b1);
      // Out-of-range bases saturate to binary or hex.
      send_item(32'd5, 5'd0, 1'b0);
      send_item(32'h0000_00FF, 5'd1, 1'b1);
      send_item(32'hABCD_EF01, 5'd17, 1'b1);
      send_item(32'hABCD_EF01, 5'd31, 1'b0);
      send_item(32'h5555_5555, 5'd4, 1'b0);
      send_item(32'h7FFF_FFFF, 5'd8, 1'b1);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_item(pick_value(), pick_radix(), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_steady_flow();
      steady_mode = 1'b1;
      test_random(20);
      steady_mode = 1'b0;
   endtask

   task automatic test_output_stall();
      // Hold the receiver off while short items keep coming, so the input fills.
      rx_hold_cycles = 300;
      repeat (32) send_item(VALUE_W'($urandom_range(0, 999)), 5'd10, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_pause_after_drain();
      wait_results_drained();
      test_random(8);
   endtask

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_value      = '0;
      req_radix      = RADIX_W'(10);
      req_upper_case = 1'b0;
      rsp_pop        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(20);
      test_steady_flow();
      test_output_stall();
      test_pause_after_drain();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_digits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (rx_hold_cycles != 0) begin
         rsp_pop <= 1'b0;
         rx_hold_cycles = rx_hold_cycles - 1;
      end else if (steady_mode) begin
         rsp_pop <= 1'b1;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= 19);
      end
   end

   always @(posedge clock) begin
      digit_exp_type want;
      if (!reset && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                     $time, rsp_digit_char, rsp_last);
            error_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.code) begin
               $display("%0t: digit_char mismatch, expected %h, actual %h",
                        $time, want.code, rsp_digit_char);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
